// File: sv/circular_byte_deque_top_assert.svh
// ----------------------------------------------------------------------------
// circular_byte_deque_top_assert.svh
// Assertion macros for the byte deque; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_BYTE_DEQUE_TOP_ASSERT_SVH
`define CIRCULAR_BYTE_DEQUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent holds, consequent holds in the same cycle
`define CBD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque assertion failed");
// antecedent holds, consequent holds in the next cycle
`define CBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque assertion failed");
`else
`define CBD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CBD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared constants, codes and types of the byte deque.
// ----------------------------------------------------------------------------
package cbd_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 8;
   localparam int MODE_W        = 2;
   localparam int STATUS_W      = 2;

   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PUSH_BACK,
      OP_PUSH_FRONT,
      OP_POP_FRONT,
      OP_POP_BACK
   } cbd_op_type;

   typedef struct packed {
      cbd_op_type        op;
      logic [DATA_W-1:0] data;
   } cbd_ctrl_type;

endpackage

// File: sv/cbd_if.sv
// ----------------------------------------------------------------------------
// cbd_if
// Request and response channels of the byte deque (valid/ready).
// ----------------------------------------------------------------------------
interface cbd_req_if;
   logic                        valid;
   logic                        ready;
   logic [cbd_pkg::MODE_W-1:0]  mode;
   logic [cbd_pkg::DATA_W-1:0]  data_in;

   modport source (output valid, output mode, output data_in, input ready);
   modport sink   (input valid, input mode, input data_in, output ready);
endinterface

interface cbd_rsp_if #(
   parameter int COUNT_WIDTH = $clog2(cbd_pkg::DEPTH_DEFAULT + 1)
);
   logic                          valid;
   logic                          ready;
   logic [cbd_pkg::DATA_W-1:0]    data_out;
   logic [cbd_pkg::STATUS_W-1:0]  status;
   logic [COUNT_WIDTH-1:0]        count;
   logic [cbd_pkg::DATA_W-1:0]    front_byte;
   logic                          is_empty;
   logic                          is_full;

   modport source (output valid, output data_out, output status, output count,
                   output front_byte, output is_empty, output is_full, input ready);
   modport sink   (input valid, input data_out, input status, input count,
                   input front_byte, input is_empty, input is_full, output ready);
endinterface

// File: sv/circular_byte_deque_top.sv
// ----------------------------------------------------------------------------
// circular_byte_deque_top: double-ended byte queue built as a chain of cells
// Latency: the result item is valid in the cycle after the request is taken.
// A new item is taken only once the registered OR tree has settled on the
// back byte after the last change and the result slot is free or draining.
// Reset: synchronous, empties the chain and the count; cell bytes keep junk.
// ----------------------------------------------------------------------------
`include "circular_byte_deque_top_assert.svh"

module circular_byte_deque_top #(
   parameter int DEPTH = cbd_pkg::DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   cbd_req_if.sink      req,
   cbd_rsp_if.source    rsp
);

   localparam int CountWidth  = $clog2(DEPTH + 1);
   localparam int TreeLevels  = $clog2(DEPTH);
   localparam int SettleWidth = $clog2(TreeLevels + 1);

   // The front of the deque always sits in cell 0 and entries are packed
   // toward it, so a front push or pop shifts the whole chain by one cell,
   // a back push fills the first free cell and a back pop frees the last
   // occupied one. The popped back byte comes from the OR tree.

   cbd_pkg::cbd_ctrl_type         ctrl;
   logic [DEPTH-1:0]              occ_vec;
   logic [cbd_pkg::DATA_W-1:0]    cell_data [DEPTH];
   logic [cbd_pkg::DATA_W-1:0]    cell_back [DEPTH];
   logic [cbd_pkg::DATA_W-1:0]    tree_root;

   logic [CountWidth-1:0]         count_ff;
   logic [CountWidth-1:0]         count_in;
   logic [SettleWidth-1:0]        settle_ff;
   logic                          rsp_valid_ff;
   logic [cbd_pkg::DATA_W-1:0]    data_out_ff;
   logic [cbd_pkg::DATA_W-1:0]    data_out_in;
   logic [cbd_pkg::STATUS_W-1:0]  status_ff;
   logic [cbd_pkg::STATUS_W-1:0]  status_in;

   logic                          accept;
   logic                          full;
   logic                          empty;

   // ---- cell chain --------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                       left_occ;
      logic [cbd_pkg::DATA_W-1:0] left_data;
      logic                       right_occ;
      logic [cbd_pkg::DATA_W-1:0] right_data;

      if (i == 0) begin : g_head
         // the head sees the incoming byte as its left neighbor
         assign left_occ  = 1'b1;
         assign left_data = ctrl.data;
      end else begin : g_mid_left
         assign left_occ  = occ_vec[i-1];
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_occ  = 1'b0;
         assign right_data = '0;
      end else begin : g_mid_right
         assign right_occ  = occ_vec[i+1];
         assign right_data = cell_data[i+1];
      end

      cbd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_occ   (left_occ),
         .left_data  (left_data),
         .right_occ  (right_occ),
         .right_data (right_data),
         .occ        (occ_vec[i]),
         .data       (cell_data[i]),
         .back_byte  (cell_back[i])
      );
   end

   cbd_back_tree #(
      .LEAVES (DEPTH),
      .WIDTH  (cbd_pkg::DATA_W)
   ) u_back_tree (
      .clock (clock),
      .leaf  (cell_back),
      .root  (tree_root)
   );

   // ---- request decode ----------------------------------------------------
   // Take a new item only once the tree has settled and the result slot is
   // free or draining this cycle.
   assign req.ready = (settle_ff == '0) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign full      = (count_ff == CountWidth'(DEPTH));
   assign empty     = (count_ff == '0);

   always_comb begin
      ctrl.op     = cbd_pkg::OP_HOLD;
      ctrl.data   = req.data_in;
      count_in    = count_ff;
      status_in   = cbd_pkg::STATUS_DONE;
      data_out_in = '0;
      if (accept) begin
         case (req.mode)
            cbd_pkg::MODE_PUSH_BACK, cbd_pkg::MODE_PUSH_FRONT: begin
               if (full) begin
                  status_in = cbd_pkg::STATUS_FULL;
               end else begin
                  ctrl.op  = (req.mode == cbd_pkg::MODE_PUSH_BACK) ?
                             cbd_pkg::OP_PUSH_BACK : cbd_pkg::OP_PUSH_FRONT;
                  count_in = count_ff + CountWidth'(1);
               end
            end
            cbd_pkg::MODE_POP_FRONT: begin
               if (empty) begin
                  status_in = cbd_pkg::STATUS_EMPTY;
               end else begin
                  ctrl.op     = cbd_pkg::OP_POP_FRONT;
                  count_in    = count_ff - CountWidth'(1);
                  data_out_in = cell_data[0];
               end
            end
            cbd_pkg::MODE_POP_BACK: begin
               if (empty) begin
                  status_in = cbd_pkg::STATUS_EMPTY;
               end else begin
                  ctrl.op     = cbd_pkg::OP_POP_BACK;
                  count_in    = count_ff - CountWidth'(1);
                  data_out_in = tree_root;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ---- control registers -------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         settle_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         // hold off new items while the tree catches up with the chain
         if (accept) begin
            settle_ff <= SettleWidth'(TreeLevels);
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - SettleWidth'(1);
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---- result payload ----------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         data_out_ff <= data_out_in;
         status_ff   <= status_in;
      end
   end

   // The chain does not move while a result waits, so the count and the
   // front cell can drive the remaining fields directly.
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.data_out   = data_out_ff;
   assign rsp.status     = status_ff;
   assign rsp.count      = count_ff;
   assign rsp.front_byte = occ_vec[0] ? cell_data[0] : '0;
   assign rsp.is_empty   = empty;
   assign rsp.is_full    = full;

   // ---- assertions --------------------------------------------------------
   `CBD_ASSERT_IMPLY(a_count_matches_cells, clock, reset, 1'b1, ($countones(occ_vec) == count_ff))
   `CBD_ASSERT_IMPLY(a_count_in_range, clock, reset, 1'b1, (count_ff <= CountWidth'(DEPTH)))
   `CBD_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid_ff)
   `CBD_ASSERT_NEXT(a_empty_pop_refused, clock, reset, (accept && empty && req.mode[1]), (status_ff == cbd_pkg::STATUS_EMPTY))

endmodule

// File: sv/cbd_cell.sv
// ----------------------------------------------------------------------------
// cbd_cell
// One slot of the deque chain: a byte and an occupied flag.
// ----------------------------------------------------------------------------
module cbd_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  cbd_pkg::cbd_ctrl_type       ctrl,
   input  logic                        left_occ,
   input  logic [cbd_pkg::DATA_W-1:0]  left_data,
   input  logic                        right_occ,
   input  logic [cbd_pkg::DATA_W-1:0]  right_data,
   output logic                        occ,
   output logic [cbd_pkg::DATA_W-1:0]  data,
   output logic [cbd_pkg::DATA_W-1:0]  back_byte
);

   logic                       occ_ff;
   logic                       occ_in;
   logic [cbd_pkg::DATA_W-1:0] data_ff;
   logic [cbd_pkg::DATA_W-1:0] data_in;

   always_comb begin
      occ_in  = occ_ff;
      data_in = data_ff;
      case (ctrl.op)
         cbd_pkg::OP_PUSH_FRONT: begin
            occ_in  = left_occ;
            data_in = left_data;
         end
         cbd_pkg::OP_POP_FRONT: begin
            occ_in  = right_occ;
            data_in = right_data;
         end
         cbd_pkg::OP_PUSH_BACK: begin
            // first free slot takes the byte
            if (!occ_ff && left_occ) begin
               occ_in  = 1'b1;
               data_in = ctrl.data;
            end
         end
         cbd_pkg::OP_POP_BACK: begin
            if (occ_ff && !right_occ) begin
               occ_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign occ       = occ_ff;
   assign data      = data_ff;
   // last occupied slot offers its byte to the back tree
   assign back_byte = (occ_ff && !right_occ) ? data_ff : '0;

endmodule

// File: sv/cbd_back_tree.sv
// ----------------------------------------------------------------------------
// cbd_back_tree
// Registered OR tree that gathers the byte of the last occupied cell.
// ----------------------------------------------------------------------------
module cbd_back_tree #(
   parameter int LEAVES = cbd_pkg::DEPTH_DEFAULT,
   parameter int WIDTH  = cbd_pkg::DATA_W
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] leaf [LEAVES],
   output logic [WIDTH-1:0] root
);

   localparam int Levels = $clog2(LEAVES);
   localparam int Span   = 1 << Levels;

   logic [WIDTH-1:0] pad     [Span];
   logic [WIDTH-1:0] node_ff [1:Span-1];
   logic [WIDTH-1:0] node_in [1:Span-1];

   for (genvar i = 0; i < Span; i++) begin : g_pad
      if (i < LEAVES) begin : g_used
         assign pad[i] = leaf[i];
      end else begin : g_zero
         assign pad[i] = '0;
      end
   end

   for (genvar k = 1; k < Span; k++) begin : g_node
      if (2 * k >= Span) begin : g_bottom
         assign node_in[k] = pad[2*k-Span] | pad[2*k+1-Span];
      end else begin : g_inner
         assign node_in[k] = node_ff[2*k] | node_ff[2*k+1];
      end
      always_ff @(posedge clock) begin
         node_ff[k] <= node_in[k];
      end
   end

   assign root = node_ff[1];

endmodule
